/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/wgm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int LEN_W = 6;
  localparam int BYTE_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

  localparam logic [BYTE_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [BYTE_W-1:0] ANY_CHAR = 8'h3F;

  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } wgm_op_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic              advance;
    wgm_op_t           op;
    logic [BYTE_W-1:0] text_byte;
  } wgm_cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/wildcard_glob_matcher_unit.sv */
// Streaming glob matcher: '*' matches any run of bytes, '?' any one byte, all
// other pattern bytes match themselves. A start request (op 0) resets the match
// row; a byte request (op 1) advances it by one text byte. Every request gives
// exactly one result, matched, true when the text since the last start matches
// the whole pattern. One request is taken per cycle unless in_stall is set; its
// result goes to the output register, or to the skid if that is stalled. The
// row is a chain of MAX_PATTERN cells, one per pattern position; the star
// closure ripples through the chain in the same cycle, so the chain length sets
// the clock path, not the rate. A two-entry output stage (register plus skid)
// keeps taking requests while one result waits; in_stall rises only when both
// entries hold results. Write the pattern only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wildcard_glob_matcher_unit
  import wgm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_op,
  input  wire logic [BYTE_W-1:0]      in_text_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_matched
);

  localparam int LenIdxW = $clog2(MAX_PATTERN + 1);

  logic [BYTE_W-1:0]  pattern_r [MAX_PATTERN];
  logic [LEN_W-1:0]   len_r;
  logic [LenIdxW-1:0] eff_len;
  logic               row0_r;
  logic               row0_nxt;
  logic               accept;
  wgm_cell_ctrl_t     ctrl;
  logic [MAX_PATTERN:0] old_row;
  logic [MAX_PATTERN:0] new_row;
  logic               matched_nxt;

  // configuration registers
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pat
    localparam int WordSel = i / 8;
    localparam int ByteLsb = (i % 8) * BYTE_W;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pattern_r[i] <= '0;
      end else if (cfg_we &&
                   cfg_index == (REG_PATTERN_0 + CFG_INDEX_W'(WordSel))) begin
        pattern_r[i] <= cfg_wdata[ByteLsb +: BYTE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_we && cfg_index == REG_PATTERN_LENGTH) begin
      len_r <= cfg_wdata[LEN_W-1:0];
    end
  end

  // saturate the length to the row size
  assign eff_len = (len_r > LEN_W'(MAX_PATTERN)) ? LenIdxW'(MAX_PATTERN)
                                                 : LenIdxW'(len_r);

  assign accept         = in_valid && !in_stall;
  assign ctrl.advance   = accept;
  assign ctrl.op        = wgm_op_t'(in_op);
  assign ctrl.text_byte = in_text_byte;

  // position zero: set on start, clear on any text byte
  assign row0_nxt   = (ctrl.op == OP_START);
  assign old_row[0] = row0_r;
  assign new_row[0] = row0_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= 1'b1;
    end else if (accept) begin
      row0_r <= row0_nxt;
    end
  end

  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    wgm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .pat_byte (pattern_r[j-1]),
      .in_use   (eff_len >= LenIdxW'(j)),
      .old_left (old_row[j-1]),
      .new_left (new_row[j-1]),
      .old_bit  (old_row[j]),
      .new_bit  (new_row[j])
    );
  end

  assign matched_nxt = new_row[eff_len];

  wgm_out_skid u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (accept),
    .push_matched (matched_nxt),
    .full         (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_matched  (out_matched)
  );

  `ASSERT_NOW(a_skid_behind_main, clk, rst_n, in_stall, out_valid, "skid full with output empty")
  `ASSERT_NEXT(a_skid_fills, clk, rst_n, accept && out_valid && out_stall, in_stall, "result lost while output stalled")
  `ASSERT_NEXT(a_start_row0, clk, rst_n, accept && ctrl.op == OP_START, row0_r, "start did not set position zero")
  `ASSERT_NEXT(a_byte_row0, clk, rst_n, accept && ctrl.op == OP_BYTE, !row0_r, "text byte left position zero set")

endmodule

`default_nettype wire

/* rtl/core/wgm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module wgm_cell
  import wgm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wgm_cell_ctrl_t    ctrl,
  input  wire logic [BYTE_W-1:0] pat_byte,
  input  wire logic              in_use,
  input  wire logic              old_left,
  input  wire logic              new_left,
  output logic                   old_bit,
  output logic                   new_bit
);

  logic bit_r;
  logic bit_nxt;
  logic is_star;
  logic is_hit;

  assign is_star = (pat_byte == STAR_CHAR);
  assign is_hit  = (pat_byte == ANY_CHAR) || (pat_byte == ctrl.text_byte);

  always_comb begin
    bit_nxt = 1'b0;
    if (in_use) begin
      case (ctrl.op)
        OP_START: begin
          // close over leading stars
          bit_nxt = is_star && new_left;
        end
        OP_BYTE: begin
          if (is_star) begin
            bit_nxt = new_left || bit_r;
          end else if (is_hit) begin
            bit_nxt = old_left;
          end
        end
        default: begin
          bit_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else if (ctrl.advance) begin
      bit_r <= bit_nxt;
    end
  end

  assign old_bit = bit_r;
  assign new_bit = bit_nxt;

endmodule

`default_nettype wire

/* rtl/core/wgm_out_skid.sv */
`timescale 1ns / 1ps
`default_nettype none

module wgm_out_skid
  import wgm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire logic push_matched,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic      out_matched
);

  logic main_valid_r;
  logic main_data_r;
  logic skid_valid_r;
  logic skid_data_r;
  logic take;

  assign take = main_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // drain the skid entry into the output register
      if (take) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        main_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_data_r <= push_matched;
      end else begin
        skid_data_r <= push_matched;
      end
    end
  end

  assign full        = skid_valid_r;
  assign out_valid   = main_valid_r;
  assign out_matched = main_data_r;

endmodule

`default_nettype wire

/* dv/tb_wildcard_glob_matcher_unit.sv */
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher_unit;
  import wgm_pkg::*;

  localparam int GLOB_MAX_LEN = 32;
  localparam int GAP_MAX = 16;
  localparam int LONG_HOLD = 60;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_REQUESTS = 1250;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_TOP = {CFG_INDEX_W{1'b1}};

  typedef struct {
    wgm_op_t           op;
    logic [BYTE_W-1:0] text_byte;
    int                gap;
    bit                drain;
  } glob_req_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_op = 1'b0;
  logic [BYTE_W-1:0]      in_text_byte = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_matched;

  wildcard_glob_matcher_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_text_byte(in_text_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_matched(out_matched)
  );

  always #5 clk = ~clk;

  // Shadow of the pattern registers and the match row.
  logic [CFG_DATA_W-1:0] pat_word [4];
  logic [LEN_W-1:0]      pat_len;
  logic [GLOB_MAX_LEN:0] glob_row;

  glob_req_t pending_requests [$];
  logic      expected_matched [$];

  int send_gap_max = 0;
  int recv_gap_max = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int stall_left = 0;
  int hold_left = 0;
  int failures = 0;
  int stim_count = 0;
  int quiet_cycles = 0;

  function automatic int eff_len();
    return (pat_len > GLOB_MAX_LEN) ? GLOB_MAX_LEN : int'(pat_len);
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_byte(int idx);
    return pat_word[idx / 8][(idx % 8) * 8 +: 8];
  endfunction

  function automatic logic [GLOB_MAX_LEN:0] next_glob_row(logic [GLOB_MAX_LEN:0] row,
                                                          wgm_op_t op,
                                                          logic [BYTE_W-1:0] ch);
    logic [GLOB_MAX_LEN:0] nxt;
    logic [BYTE_W-1:0]     pc;
    int                    len;
    len = eff_len();
    nxt = '0;
    nxt[0] = (op == OP_START);
    for (int j = 1; j <= len; j++) begin
      pc = pattern_byte(j - 1);
      if (op == OP_START) begin
        // close over leading stars
        nxt[j] = (pc == STAR_CHAR) && nxt[j-1];
      end else if (pc == STAR_CHAR) begin
        nxt[j] = nxt[j-1] | row[j];
      end else if (pc == ANY_CHAR || pc == ch) begin
        nxt[j] = row[j-1];
      end
    end
    return nxt;
  endfunction

  // Driver: present queued requests, predict on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        glob_row = next_glob_row(glob_row, wgm_op_t'(in_op), in_text_byte);
        expected_matched.insert(expected_matched.size(), glob_row[eff_len()]);
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() > 0 && pending_requests[0].gap > 0) begin
          pending_requests[0].gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0 && pending_requests[0].drain &&
                     expected_matched.size() != 0) begin
          // hold until every result in flight is back
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_valid <= 1'b1;
          in_op <= pending_requests[0].op;
          in_text_byte <= pending_requests[0].text_byte;
          void'(pending_requests.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare results and drive the result stall.
  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_matched.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual matched %0b",
                   $realtime, out_matched);
          failures++;
        end else begin
          want = expected_matched.pop_front();
          if (out_matched !== want) begin
            $display("%0t: matched mismatch, expected %0b, actual %0b",
                     $realtime, want, out_matched);
            failures++;
          end
        end
        stall_left = $urandom_range(0, recv_gap_max);
      end
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("wildcard_glob_matcher_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_request(input wgm_op_t op, input logic [BYTE_W-1:0] ch,
                               input bit drain);
    glob_req_t r;
    r.op = op;
    r.text_byte = ch;
    r.gap = $urandom_range(0, send_gap_max);
    r.drain = drain;
    pending_requests.insert(pending_requests.size(), r);
    stim_count++;
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_matched.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx < REG_PATTERN_LENGTH) begin
      pat_word[idx] = data;
    end else if (idx == REG_PATTERN_LENGTH) begin
      pat_len = data[LEN_W-1:0];
    end
  endtask

  task automatic write_pattern(input logic [BYTE_W-1:0] pat [GLOB_MAX_LEN],
                               input int len, input bit poke_unused);
    logic [CFG_DATA_W-1:0] word;
    for (int w = 0; w < 4; w++) begin
      for (int b = 0; b < 8; b++) word[b*8 +: 8] = pat[w*8 + b];
      write_reg(REG_PATTERN_0 + CFG_INDEX_W'(w), word);
    end
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    if (poke_unused) begin
      write_reg(CFG_INDEX_W'($urandom_range(REG_PATTERN_LENGTH + 1, REG_INDEX_TOP)),
                {$urandom, $urandom});
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_text_byte();
    case ($urandom_range(0, 7))
      0, 1, 2: return "a";
      3, 4:    return "b";
      5:       return "c";
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_pattern_byte();
    case ($urandom_range(0, 9))
      0, 1:    return STAR_CHAR;
      2:       return ANY_CHAR;
      3, 4, 5: return "a";
      6, 7:    return "b";
      8:       return "c";
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // Start a text and feed it; well-formed texts are expanded from the pattern.
  task automatic queue_text(input bit well_formed);
    logic [BYTE_W-1:0] text [$];
    logic [BYTE_W-1:0] pc;
    int                n;
    queue_request(OP_START, BYTE_W'($urandom), 1'b0);
    if (well_formed) begin
      for (int k = 0; k < eff_len(); k++) begin
        pc = pattern_byte(k);
        if (pc == STAR_CHAR) begin
          n = $urandom_range(0, 3);
          repeat (n) text.insert(text.size(), pick_text_byte());
        end else if (pc == ANY_CHAR) begin
          text.insert(text.size(), BYTE_W'($urandom));
        end else begin
          text.insert(text.size(), pc);
        end
      end
      if (text.size() > 0 && $urandom_range(0, 3) == 0) begin
        text[$urandom_range(0, text.size() - 1)] = pick_text_byte();
      end
      if ($urandom_range(0, 4) == 0) text.insert(text.size(), pick_text_byte());
    end else begin
      n = $urandom_range(0, 10);
      repeat (n) text.insert(text.size(), pick_text_byte());
    end
    foreach (text[i]) queue_request(OP_BYTE, text[i], 1'b0);
  endtask

  task automatic queue_noise(input int count);
    repeat (count) begin
      queue_request($urandom_range(0, 3) == 0 ? OP_START : OP_BYTE, BYTE_W'($urandom),
                    $urandom_range(0, 49) == 0);
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] pat [GLOB_MAX_LEN];
    int                len;

    for (int w = 0; w < 4; w++) pat_word[w] = '0;
    pat_len = '0;
    glob_row = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty pattern out of reset: a byte with no start, then a fresh start.
    queue_request(OP_BYTE, 8'h00, 1'b0);
    queue_request(OP_START, 8'hFF, 1'b0);
    queue_request(OP_BYTE, 8'hFF, 1'b0);
    queue_request(OP_BYTE, 8'h5A, 1'b0);
    wait_idle();

    // All-ones pattern with an oversized length saturates to the full row.
    foreach (pat[i]) pat[i] = 8'hFF;
    write_pattern(pat, 63, 1'b0);
    send_gap_max = GAP_MAX;
    queue_request(OP_START, 8'h00, 1'b0);
    queue_request(OP_BYTE, 8'hFF, 1'b0);
    queue_request(OP_BYTE, 8'hFF, 1'b0);
    wait_idle();

    // Star, any, zero byte, all-ones byte, trailing star.
    foreach (pat[i]) pat[i] = 8'h00;
    pat[0] = STAR_CHAR;
    pat[1] = ANY_CHAR;
    pat[2] = 8'h00;
    pat[3] = 8'hFF;
    pat[4] = STAR_CHAR;
    write_pattern(pat, 5, 1'b1);
    recv_gap_max = GAP_MAX;
    queue_request(OP_START, 8'h00, 1'b0);
    queue_request(OP_BYTE, "x", 1'b0);
    queue_request(OP_BYTE, 8'h00, 1'b0);
    queue_request(OP_BYTE, 8'hFF, 1'b0);
    queue_request(OP_BYTE, "z", 1'b0);
    wait_idle();

    // Leading stars close over at start.
    pat[0] = STAR_CHAR;
    pat[1] = STAR_CHAR;
    write_pattern(pat, 2, 1'b0);
    queue_request(OP_START, 8'h00, 1'b0);
    queue_request(OP_BYTE, 8'h7E, 1'b0);
    wait_idle();

    // Swap to an all-zero empty pattern in the middle of a text.
    foreach (pat[i]) pat[i] = 8'h00;
    write_pattern(pat, 0, 1'b0);
    queue_request(OP_BYTE, 8'h00, 1'b0);
    queue_request(OP_START, 8'h00, 1'b0);
    queue_request(OP_BYTE, 8'h55, 1'b0);
    wait_idle();

    // Fill the block behind a long result hold-off, then pause for a drain.
    foreach (pat[i]) pat[i] = pick_pattern_byte();
    write_pattern(pat, 4, 1'b0);
    send_gap_max = 0;
    recv_gap_max = 0;
    hold_asked++;
    queue_text(1'b1);
    queue_noise(20);
    queue_request(OP_START, 8'h00, 1'b1);
    queue_noise(6);
    wait_idle();

    stim_count = 0;
    while (stim_count < RANDOM_REQUESTS) begin
      foreach (pat[i]) pat[i] = pick_pattern_byte();
      case ($urandom_range(0, 7))
        0:       len = 0;
        1:       len = GLOB_MAX_LEN;
        2:       len = $urandom_range(GLOB_MAX_LEN + 1, 63);
        default: len = $urandom_range(1, 8);
      endcase
      write_pattern(pat, len, $urandom_range(0, 5) == 0);
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0:       queue_noise($urandom_range(1, 12));
          1:       queue_text(1'b0);
          default: queue_text(1'b1);
        endcase
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (expected_matched.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, expected_matched.size());
      failures++;
    end
    if (failures == 0) begin
      $display("wildcard_glob_matcher_unit regression: pass");
    end else begin
      $display("wildcard_glob_matcher_unit regression: fail");
    end
    $finish;
  end

endmodule
